// ----- sv/quaternion_arithmetic_unit_macros.svh -----
// Assertion macros shared by the checker of the quaternion arithmetic unit.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef QUATERNION_ARITHMETIC_UNIT_MACROS_SVH
`define QUATERNION_ARITHMETIC_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QAU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qau: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define QAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qau: next-cycle check failed");

`endif

// ----- sv/qau_pkg.sv -----
// Package of the quaternion arithmetic unit: widths, pipeline depths, codes,
// shared structs and the saturation function. Depends on nothing.
package qau_pkg;

  localparam int unsigned FracBits  = 30;
  localparam int unsigned DataW     = 32;
  localparam int unsigned NumLanes  = 4;
  localparam int unsigned SqW       = 2 * DataW;
  localparam int unsigned SumW      = SqW + 1;
  localparam int unsigned MagW      = DataW + 1;
  localparam int unsigned ThrW      = 16;
  localparam logic [ThrW-1:0] ThrReset = 16'd107;

  // Square root: two adder stages, then one stage per result bit.
  localparam int unsigned RootSteps = MagW;
  localparam int unsigned RootW     = SumW + 1;
  localparam int unsigned SqrtLat   = RootSteps + 2;
  localparam int unsigned LaneDelay = SqrtLat - 1;

  // Divider: quotient of |a| * 2^DivShift by the divisor, one bit per stage.
  localparam int unsigned QuotBits  = DataW + 2;
  localparam int unsigned DivShift  = 2 * FracBits + 1;
  localparam int unsigned RemShift  = DivShift - QuotBits;
  localparam int unsigned DivLat    = QuotBits + 2;

  localparam int unsigned TotalLat  = 2 + SqrtLat + DivLat;

  localparam logic [DataW-1:0] PosMax = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0] NegMax = 32'h8000_0000;

  typedef enum logic [2:0] {
    ActAdd       = 3'd0,
    ActSub       = 3'd1,
    ActScale     = 3'd2,
    ActNegate    = 3'd3,
    ActConj      = 3'd4,
    ActInverse   = 3'd5,
    ActNormalize = 3'd6
  } action_e;

  typedef enum logic [1:0] {
    StOk   = 2'd0,
    StZero = 2'd1,
    StOvf  = 2'd2
  } status_e;

  typedef struct packed {
    logic [DataW-1:0] val;
    logic             ov;
  } sat_t;

  typedef struct packed {
    logic [DataW-1:0] mag;
    logic             neg;
    logic [DataW-1:0] pre;
    logic             pre_ov;
  } lane_t;

  typedef struct packed {
    action_e                   action;
    lane_t [NumLanes-1:0]      lane;
  } item_t;

  typedef struct packed {
    logic [DataW-1:0] r_x;
    logic [DataW-1:0] r_y;
    logic [DataW-1:0] r_z;
    logic [DataW-1:0] r_w;
    logic [MagW-1:0]  magn;
    status_e          status;
  } result_t;

  // Sign and magnitude to two's complement, clipped to the 32-bit range.
  function automatic sat_t sat32(input logic neg, input logic [QuotBits-1:0] mag);
    sat_t                res;
    logic [QuotBits-1:0] neg_mag;
    neg_mag = ~mag + QuotBits'(1);
    if (!neg) begin
      if (mag > QuotBits'(PosMax)) begin
        res = '{val: PosMax, ov: 1'b1};
      end else begin
        res = '{val: mag[DataW-1:0], ov: 1'b0};
      end
    end else begin
      if (mag > QuotBits'(NegMax)) begin
        res = '{val: NegMax, ov: 1'b1};
      end else begin
        res = '{val: neg_mag[DataW-1:0], ov: 1'b0};
      end
    end
    return res;
  endfunction

endpackage

// ----- sv/qau_front.sv -----
// Input stage and per-lane front end: magnitudes, squares, scale products and
// the results of the simple actions. Depends on qau_pkg.
module qau_front
  import qau_pkg::*;
(
  input  logic                           clk_i,
  input  logic                           en_i,
  input  action_e                        action_i,
  input  logic [NumLanes-1:0][DataW-1:0] a_i,
  input  logic [NumLanes-1:0][DataW-1:0] b_i,
  input  logic [DataW-1:0]               scale_i,
  output logic [SqW-1:0]                 sq_o [NumLanes],
  output item_t                          item_o
);

  action_e                        act_a_q;
  logic [NumLanes-1:0][DataW-1:0] a_q;
  logic [NumLanes-1:0][DataW-1:0] b_q;
  logic [DataW-1:0]               s_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      act_a_q <= action_i;
      a_q     <= a_i;
      b_q     <= b_i;
      s_q     <= scale_i;
    end
  end

  logic             s_neg;
  logic [DataW-1:0] s_mag;
  assign s_neg = s_q[DataW-1];
  assign s_mag = s_neg ? (~s_q + DataW'(1)) : s_q;

  action_e          act_b_q;
  action_e          act_c_q;
  logic [SqW-1:0]   prod_b_q [NumLanes];
  logic [DataW-1:0] mag_b_q  [NumLanes];
  logic             neg_b_q  [NumLanes];
  sat_t             pre_b_q  [NumLanes];
  sat_t             fin_c    [NumLanes];
  lane_t            lane_c_q [NumLanes];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      act_b_q <= act_a_q;
      act_c_q <= act_b_q;
    end
  end

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    localparam bit IsVec = (l != NumLanes - 1);

    logic                a_neg;
    logic [DataW-1:0]    a_mag;
    logic [DataW:0]      sum;
    logic [DataW:0]      dif;
    logic [DataW:0]      sum_neg;
    logic [DataW:0]      dif_neg;
    logic [QuotBits-1:0] sum_mag;
    logic [QuotBits-1:0] dif_mag;
    logic [SqW-1:0]      sq_d;
    logic [SqW-1:0]      prod_d;
    logic                res_neg;
    sat_t                pre_d;
    logic [SqW-1:0]      rnd;
    logic [QuotBits-1:0] scaled;

    assign a_neg   = a_q[l][DataW-1];
    assign a_mag   = a_neg ? (~a_q[l] + DataW'(1)) : a_q[l];
    assign sum     = {a_q[l][DataW-1], a_q[l]} + {b_q[l][DataW-1], b_q[l]};
    assign dif     = {a_q[l][DataW-1], a_q[l]} - {b_q[l][DataW-1], b_q[l]};
    assign sum_neg = ~sum + (DataW + 1)'(1);
    assign dif_neg = ~dif + (DataW + 1)'(1);
    assign sum_mag = sum[DataW] ? QuotBits'(sum_neg) : QuotBits'(sum);
    assign dif_mag = dif[DataW] ? QuotBits'(dif_neg) : QuotBits'(dif);
    assign sq_d    = a_mag * a_mag;
    assign prod_d  = a_mag * s_mag;

    always_comb begin
      res_neg = a_neg;
      pre_d   = '0;
      unique case (act_a_q)
        ActAdd:    pre_d = sat32(sum[DataW], sum_mag);
        ActSub:    pre_d = sat32(dif[DataW], dif_mag);
        ActScale:  res_neg = a_neg ^ s_neg;
        ActNegate: pre_d = sat32(!a_neg, QuotBits'(a_mag));
        ActConj: begin
          if (IsVec) begin
            pre_d = sat32(!a_neg, QuotBits'(a_mag));
          end else begin
            pre_d = '{val: a_q[l], ov: 1'b0};
          end
        end
        ActInverse: begin
          res_neg = IsVec ? !a_neg : a_neg;
          // Fallback for a zero norm: clip toward the sign of the conjugate.
          if (a_q[l] != '0) begin
            pre_d.val = res_neg ? NegMax : PosMax;
          end
        end
        ActNormalize: pre_d.val = a_q[l];
        default:      pre_d = '0;
      endcase
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_o[l]     <= sq_d;
        prod_b_q[l] <= prod_d;
        mag_b_q[l]  <= a_mag;
        neg_b_q[l]  <= res_neg;
        pre_b_q[l]  <= pre_d;
      end
    end

    // Round the scale product to nearest, ties away from zero.
    assign rnd      = prod_b_q[l] + (SqW'(1) << (FracBits - 1));
    assign scaled   = rnd[FracBits +: QuotBits];
    assign fin_c[l] = (act_b_q == ActScale) ? sat32(neg_b_q[l], scaled) : pre_b_q[l];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        lane_c_q[l] <= '{mag: mag_b_q[l], neg: neg_b_q[l],
                         pre: fin_c[l].val, pre_ov: fin_c[l].ov};
      end
    end
  end

  always_comb begin
    item_o.action = act_c_q;
    for (int k = 0; k < NumLanes; k++) begin
      item_o.lane[k] = lane_c_q[k];
    end
  end

endmodule

// ----- sv/qau_isqrt.sv -----
// Pipelined norm unit: sum of the four squares, then an integer square root
// that settles one result bit per stage. Depends on qau_pkg.
module qau_isqrt
  import qau_pkg::*;
(
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [SqW-1:0]  sq_i [NumLanes],
  output logic [SumW-1:0] sum_o,
  output logic [MagW-1:0] magn_o
);

  logic [SumW-1:0] p0_q;
  logic [SumW-1:0] p1_q;
  logic [SumW-1:0] s_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q <= SumW'(sq_i[0]) + SumW'(sq_i[1]);
      p1_q <= SumW'(sq_i[2]) + SumW'(sq_i[3]);
      s_q  <= p0_q + p1_q;
    end
  end

  logic [RootW-1:0] x_q   [RootSteps];
  logic [RootW-1:0] res_q [RootSteps];
  logic [SumW-1:0]  sum_q [RootSteps];

  for (genvar g = 0; g < RootSteps; g++) begin : g_root
    localparam int unsigned K = RootSteps - 1 - g;
    localparam logic [RootW-1:0] Bit = RootW'(1) << (2 * K);

    logic [RootW-1:0] x_in;
    logic [RootW-1:0] res_in;
    logic [SumW-1:0]  sum_in;
    logic [RootW-1:0] trial;

    if (g == 0) begin : g_first
      assign x_in   = RootW'(s_q);
      assign res_in = '0;
      assign sum_in = s_q;
    end else begin : g_next
      assign x_in   = x_q[g-1];
      assign res_in = res_q[g-1];
      assign sum_in = sum_q[g-1];
    end

    assign trial = res_in + Bit;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sum_q[g] <= sum_in;
        if (x_in >= trial) begin
          x_q[g]   <= x_in - trial;
          res_q[g] <= (res_in >> 1) + Bit;
        end else begin
          x_q[g]   <= x_in;
          res_q[g] <= res_in >> 1;
        end
      end
    end
  end

  assign sum_o  = sum_q[RootSteps-1];
  assign magn_o = res_q[RootSteps-1][MagW-1:0];

endmodule

// ----- sv/qau_div.sv -----
// One lane of the pipelined restoring divider for inverse and normalize, with
// rounding and saturation at its end. Depends on qau_pkg.
module qau_div
  import qau_pkg::*;
(
  input  logic            clk_i,
  input  logic            en_i,
  input  action_e         action_i,
  input  lane_t           lane_i,
  input  logic [SumW-1:0] sum_i,
  input  logic [MagW-1:0] magn_i,
  input  logic [ThrW-1:0] thr_i,
  output sat_t            res_o
);

  typedef struct packed {
    logic             use_div;
    logic             ovf;
    logic             neg;
    logic [DataW-1:0] pre;
    logic             pre_ov;
  } div_ctl_t;

  logic [SumW-1:0]     rem_q [QuotBits+1];
  logic [SumW-1:0]     dvs_q [QuotBits+1];
  logic [QuotBits-1:0] quo_q [QuotBits+1];
  div_ctl_t            ctl_q [QuotBits+1];

  logic            zero;
  logic [SumW-1:0] dvs_d;
  logic [SumW-1:0] rem_d;

  // Normalize divides by the norm scaled up, so both actions share one
  // dividend of |a| * 2^DivShift.
  assign zero  = magn_i <= MagW'(thr_i);
  assign dvs_d = (action_i == ActInverse) ? sum_i : (SumW'(magn_i) << FracBits);
  assign rem_d = SumW'(lane_i.mag) << RemShift;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= rem_d;
      dvs_q[0] <= dvs_d;
      quo_q[0] <= '0;
      ctl_q[0] <= '{use_div: !zero && (action_i == ActInverse || action_i == ActNormalize),
                    ovf: rem_d >= dvs_d, neg: lane_i.neg,
                    pre: lane_i.pre, pre_ov: lane_i.pre_ov};
    end
  end

  for (genvar g = 1; g <= QuotBits; g++) begin : g_step
    logic [SumW:0] shifted;
    logic [SumW:0] diff;
    logic          take;

    assign shifted = {rem_q[g-1], 1'b0};
    assign diff    = shifted - {1'b0, dvs_q[g-1]};
    assign take    = shifted >= {1'b0, dvs_q[g-1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g] <= take ? diff[SumW-1:0] : shifted[SumW-1:0];
        dvs_q[g] <= dvs_q[g-1];
        quo_q[g] <= {quo_q[g-1][QuotBits-2:0], take};
        ctl_q[g] <= ctl_q[g-1];
      end
    end
  end

  // The quotient carries one extra bit; adding one there rounds half up.
  logic [QuotBits:0]   inc;
  logic [QuotBits-1:0] q_rnd;
  div_ctl_t            ctl;
  sat_t                res_d;

  assign ctl   = ctl_q[QuotBits];
  assign inc   = {1'b0, quo_q[QuotBits]} + (QuotBits + 1)'(1);
  assign q_rnd = inc[QuotBits:1];

  always_comb begin
    if (!ctl.use_div) begin
      res_d = '{val: ctl.pre, ov: ctl.pre_ov};
    end else if (ctl.ovf) begin
      res_d = '{val: ctl.neg ? NegMax : PosMax, ov: 1'b1};
    end else begin
      res_d = sat32(ctl.neg, q_rnd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o <= res_d;
    end
  end

endmodule

// ----- sv/quaternion_arithmetic_unit.sv -----
// Top level of the quaternion arithmetic unit: handshakes, threshold register,
// alignment delays, result merge and output queue. Depends on qau_pkg and the
// qau_front, qau_isqrt and qau_div modules.
//
// Usage. An input word carries quaternions A and B, a scalar and an action
// code; it is taken when in_valid_i and in_ready_o are both high. Each word
// yields exactly one result word (R, the norm of A and a status code) on the
// output channel, taken when out_valid_o and out_ready_i are both high.
// Results leave in the order the words came in.
//
// A word passes two front stages, 35 norm stages and 36 divider stages on
// its way to the output queue. The block takes one word per cycle while the
// queue has room; the rate is set by the pipeline clock, since the square
// root and the four dividers each retire one bit per stage.
//
// A two-word output queue sits behind the pipeline. While one result waits,
// the pipeline keeps moving; in_ready_o drops only when both queue slots are
// full, and then the whole pipeline holds until the receiver takes a word.
//
// Reset empties the pipeline and queue and loads the zero threshold with 107.
// Users write the threshold (cfg_we_i, cfg_wdata_i) only when idle; unchecked.
module quaternion_arithmetic_unit
  import qau_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [ThrW-1:0]        cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [2:0]             action_i,
  input  logic signed [DataW-1:0] a_x_i,
  input  logic signed [DataW-1:0] a_y_i,
  input  logic signed [DataW-1:0] a_z_i,
  input  logic signed [DataW-1:0] a_w_i,
  input  logic signed [DataW-1:0] b_x_i,
  input  logic signed [DataW-1:0] b_y_i,
  input  logic signed [DataW-1:0] b_z_i,
  input  logic signed [DataW-1:0] b_w_i,
  input  logic signed [DataW-1:0] scale_factor_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [DataW-1:0] r_x_o,
  output logic signed [DataW-1:0] r_y_o,
  output logic signed [DataW-1:0] r_z_o,
  output logic signed [DataW-1:0] r_w_o,
  output logic [MagW-1:0]        magnitude_o,
  output logic [1:0]             status_o
);

  typedef struct packed {
    action_e         action;
    logic [MagW-1:0] magn;
  } side_t;

  // The zero threshold register.
  logic [ThrW-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // The pipeline advances as a whole whenever the output queue has room.
  logic [1:0] cnt_q;
  logic       en;
  logic       push;
  logic       pop;

  assign en         = (cnt_q != 2'd2);
  assign in_ready_o = en;

  logic [TotalLat-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[TotalLat-2:0], in_valid_i};
    end
  end

  logic [NumLanes-1:0][DataW-1:0] a_pk;
  logic [NumLanes-1:0][DataW-1:0] b_pk;
  logic [SqW-1:0]                 sq [NumLanes];
  item_t                          item;

  assign a_pk = {a_w_i, a_z_i, a_y_i, a_x_i};
  assign b_pk = {b_w_i, b_z_i, b_y_i, b_x_i};

  qau_front u_front (
    .clk_i    (clk_i),
    .en_i     (en),
    .action_i (action_e'(action_i)),
    .a_i      (a_pk),
    .b_i      (b_pk),
    .scale_i  (scale_factor_i),
    .sq_o     (sq),
    .item_o   (item)
  );

  logic [SumW-1:0] sum_sq;
  logic [MagW-1:0] magn;

  qau_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .sq_i   (sq),
    .sum_o  (sum_sq),
    .magn_o (magn)
  );

  // The lane data waits here until the norm of the same word is ready.
  item_t dly_q [LaneDelay];
  item_t aligned;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dly_q[0] <= item;
      for (int k = 1; k < LaneDelay; k++) begin
        dly_q[k] <= dly_q[k-1];
      end
    end
  end

  assign aligned = dly_q[LaneDelay-1];

  sat_t res_lane [NumLanes];

  for (genvar l = 0; l < NumLanes; l++) begin : g_div
    qau_div u_div (
      .clk_i    (clk_i),
      .en_i     (en),
      .action_i (aligned.action),
      .lane_i   (aligned.lane[l]),
      .sum_i    (sum_sq),
      .magn_i   (magn),
      .thr_i    (thr_q),
      .res_o    (res_lane[l])
    );
  end

  // Action and norm travel beside the dividers for the status merge.
  side_t side_q [DivLat];
  side_t side;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= '{action: aligned.action, magn: magn};
      for (int k = 1; k < DivLat; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign side = side_q[DivLat-1];

  // Merge the four lanes into one result word.
  logic    zero;
  logic    ov_any;
  result_t merged;

  assign zero   = side.magn <= MagW'(thr_q);
  assign ov_any = res_lane[0].ov | res_lane[1].ov | res_lane[2].ov | res_lane[3].ov;

  always_comb begin
    merged.r_x  = res_lane[0].val;
    merged.r_y  = res_lane[1].val;
    merged.r_z  = res_lane[2].val;
    merged.r_w  = res_lane[3].val;
    merged.magn = side.magn;
    priority if ((side.action == ActInverse || side.action == ActNormalize) && zero) begin
      merged.status = StZero;
    end else if (ov_any) begin
      merged.status = StOvf;
    end else begin
      merged.status = StOk;
    end
  end

  // Two-word output queue; slot 0 is always the head.
  result_t ent0_q;
  result_t ent1_q;

  assign push        = en && vld_q[TotalLat-1];
  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    unique case (cnt_q)
      2'd0: begin
        if (push) begin
          ent0_q <= merged;
        end
      end
      2'd1: begin
        if (push && pop) begin
          ent0_q <= merged;
        end else if (push) begin
          ent1_q <= merged;
        end
      end
      2'd2: begin
        if (pop) begin
          ent0_q <= ent1_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  assign r_x_o       = ent0_q.r_x;
  assign r_y_o       = ent0_q.r_y;
  assign r_z_o       = ent0_q.r_z;
  assign r_w_o       = ent0_q.r_w;
  assign magnitude_o = ent0_q.magn;
  assign status_o    = ent0_q.status;

endmodule

// ----- sv/qau_checker.sv -----
// Port-level checker for the quaternion arithmetic unit, bound to the top.
// Depends on qau_pkg and the assertion macros header.
`include "quaternion_arithmetic_unit_macros.svh"

module qau_checker
  import qau_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [DataW-1:0] r_x_o,
  input logic [DataW-1:0] r_y_o,
  input logic [DataW-1:0] r_z_o,
  input logic [DataW-1:0] r_w_o,
  input logic [MagW-1:0]  magnitude_o,
  input logic [1:0]       status_o
);

  // An overflow status means at least one component was clipped.
  `QAU_ASSERT_IMPL(a_ovf_clipped, clk_i, rst_ni, out_valid_o && status_o == StOvf, r_x_o == PosMax || r_x_o == NegMax || r_y_o == PosMax || r_y_o == NegMax || r_z_o == PosMax || r_z_o == NegMax || r_w_o == PosMax || r_w_o == NegMax)

  // The norm of four 32-bit components never exceeds 2^32.
  `QAU_ASSERT_IMPL(a_magn_range, clk_i, rst_ni, out_valid_o, !magnitude_o[MagW-1] || magnitude_o[MagW-2:0] == '0)

  // The input side stalls only when finished words are waiting.
  `QAU_ASSERT_IMPL(a_stall_full, clk_i, rst_ni, !in_ready_o, out_valid_o)

  // A word that is not taken keeps r_x_o, r_w_o, the norm and the status on the outputs.
  `QAU_ASSERT_NEXT(a_hold_word, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(r_x_o) && $stable(r_w_o) && $stable(magnitude_o) && $stable(status_o))

endmodule

bind quaternion_arithmetic_unit qau_checker u_qau_checker (.*);

// ----- tb/tb_quaternion_arithmetic_unit.sv -----
// Self-checking testbench of the quaternion arithmetic unit: a directed table,
// then random words under several zero thresholds. Depends on qau_pkg and the RTL.
module tb_quaternion_arithmetic_unit;
  import qau_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ActUnused = 3'd7;
  localparam logic [31:0] One      = 32'h4000_0000;
  localparam int unsigned WatchLimit = 2000;
  localparam int unsigned DrainWait  = TotalLat + 8;
  localparam int unsigned PhaseWords = 270;
  localparam int unsigned HoldCycles = 300;

  // One input word, components ordered x, y, z, w.
  typedef struct {
    logic [2:0]  act;
    logic [31:0] a[4];
    logic [31:0] b[4];
    logic [31:0] s;
  } quat_word_t;

  typedef struct {
    logic [31:0] r[4];
    logic [32:0] magn;
    status_e     st;
  } quat_result_t;

  // A directed row: the word, and a typed-in result where chk is set.
  typedef struct packed {
    logic [2:0]  act;
    logic [31:0] ax, ay, az, aw, bx, by, bz, bw, sc;
    logic        chk;
    logic [31:0] ex, ey, ez, ew;
    logic [32:0] em;
    status_e     es;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [ThrW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [2:0] action_i = '0;
  logic signed [DataW-1:0] a_x_i = '0, a_y_i = '0, a_z_i = '0, a_w_i = '0;
  logic signed [DataW-1:0] b_x_i = '0, b_y_i = '0, b_z_i = '0, b_w_i = '0;
  logic signed [DataW-1:0] scale_factor_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [DataW-1:0] r_x_o, r_y_o, r_z_o, r_w_o;
  logic [MagW-1:0] magnitude_o;
  logic [1:0] status_o;

  // Testbench copy of the threshold register.
  logic [15:0] zero_thr = ThrReset;
  quat_result_t expected_results[$];
  int unsigned mismatches = 0;
  bit quiet = 1'b0;      // no idling in the last phase
  bit hold_req = 1'b0;   // asks the receiver for one long hold-off
  bit stim_done = 1'b0;

  always #6 clk_i = ~clk_i;

  quaternion_arithmetic_unit i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .action_i,
    .a_x_i, .a_y_i, .a_z_i, .a_w_i, .b_x_i, .b_y_i, .b_z_i, .b_w_i,
    .scale_factor_i, .out_valid_o, .out_ready_i,
    .r_x_o, .r_y_o, .r_z_o, .r_w_o, .magnitude_o, .status_o
  );

  // ---------------------------------------------------------------------------
  // Predictor. Arithmetic runs on 64-bit values, mostly sign/magnitude (the sum of
  // squares on 65 bits), so nothing overflows before the final saturation to 32 bits.
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] abs_of(logic [31:0] v);
    longint sv;
    sv = longint'($signed(v));
    return (sv < 0) ? 64'(-sv) : 64'(sv);
  endfunction

  function automatic logic [31:0] clip32(logic neg, logic [63:0] mag, ref bit ov);
    if (!neg) begin
      if (mag > 64'(PosMax)) begin
        ov = 1'b1;
        return PosMax;
      end
      return mag[31:0];
    end
    if (mag > 64'(NegMax)) begin
      ov = 1'b1;
      return NegMax;
    end
    return 32'(-mag);
  endfunction

  // Bitwise integer square root, floor.
  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res, probe;
    res = '0;
    probe = 64'h4000_0000_0000_0000;
    while (probe > x) probe = probe >> 2;
    while (probe != 0) begin
      if (x >= res + probe) begin
        x = x - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res;
  endfunction

  // Rounded n * 2^k / d with ties up; a value above 2^33 means overflow.
  function automatic logic [63:0] round_div_shl(logic [63:0] n, int k, logic [63:0] d);
    logic [63:0] q, rem;
    logic carry;
    q = n / d;
    rem = n % d;
    for (int i = 0; i < k; i++) begin
      carry = rem[63];
      rem = rem << 1;
      q = q << 1;
      if (carry || rem >= d) begin
        rem = rem - d;
        q[0] = 1'b1;
      end
      if (q > (64'd1 << 33)) return 64'd1 << 34;
    end
    carry = rem[63];
    if (carry || (rem << 1) >= d) q = q + 1;
    return q;
  endfunction

  function automatic quat_result_t predict_quat(quat_word_t w, logic [15:0] thr);
    quat_result_t res;
    logic [64:0] sum;
    logic [63:0] lo, magn, q, m;
    longint v;
    bit big, ov, neg;
    sum = '0;
    ov = 1'b0;
    for (int i = 0; i < 4; i++) sum = sum + 65'(abs_of(w.a[i]) * abs_of(w.a[i]));
    big = sum[64];
    lo = sum[63:0];
    // The sum only reaches 2^64 when every component is the most negative value.
    magn = big ? (64'd1 << 32) : int_sqrt(lo);
    for (int i = 0; i < 4; i++) begin
      neg = w.a[i][31];
      res.r[i] = '0;
      case (w.act)
        ActAdd, ActSub: begin
          v = (w.act == ActAdd) ? longint'($signed(w.a[i])) + longint'($signed(w.b[i]))
                                : longint'($signed(w.a[i])) - longint'($signed(w.b[i]));
          res.r[i] = clip32(v < 0, (v < 0) ? 64'(-v) : 64'(v), ov);
        end
        ActScale: begin
          m = abs_of(w.a[i]) * abs_of(w.s);
          m = (m + (64'd1 << (FracBits - 1))) >> FracBits;
          res.r[i] = clip32(neg != w.s[31], m, ov);
        end
        ActNegate: res.r[i] = clip32(!neg, abs_of(w.a[i]), ov);
        ActConj: begin
          if (i < 3) res.r[i] = clip32(!neg, abs_of(w.a[i]), ov);
          else res.r[i] = w.a[i];
        end
        ActInverse: begin
          if (i < 3) neg = !neg;
          if (w.a[i] == 0) res.r[i] = '0;
          else if (magn <= 64'(thr)) res.r[i] = neg ? NegMax : PosMax;
          else begin
            if (big) q = round_div_shl(abs_of(w.a[i]), 2 * FracBits - 1, 64'd1 << 63);
            else q = round_div_shl(abs_of(w.a[i]), 2 * FracBits, lo);
            res.r[i] = clip32(neg, q, ov);
          end
        end
        ActNormalize: begin
          if (magn <= 64'(thr)) res.r[i] = w.a[i];
          else res.r[i] = clip32(neg, round_div_shl(abs_of(w.a[i]), FracBits, magn), ov);
        end
        default: res.r[i] = '0;
      endcase
    end
    res.magn = magn[32:0];
    if ((w.act == ActInverse || w.act == ActNormalize) && magn <= 64'(thr)) res.st = StZero;
    else if (ov) res.st = StOvf;
    else res.st = StOk;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table. Rows with chk set carry a result read straight off the
  // arithmetic; the others are predicted. Threshold is the reset value here.
  // ---------------------------------------------------------------------------
  localparam logic [31:0] P = PosMax, N = NegMax, Z = 32'd0;
  localparam dir_row_t DirTable[20] = '{
    // all zeros
    '{ActAdd, Z, Z, Z, Z, Z, Z, Z, Z, Z, 1'b1, Z, Z, Z, Z, 33'd0, StOk},
    // positive overflow on add
    '{ActAdd, P, P, P, P, P, P, P, P, Z, 1'b1, P, P, P, P, 33'h0_FFFF_FFFE, StOvf},
    // negative overflow on sub, largest norm
    '{ActSub, N, N, N, N, P, P, P, P, Z, 1'b1, N, N, N, N, 33'h1_0000_0000, StOvf},
    // one times one
    '{ActScale, One, One, One, One, Z, Z, Z, Z, One, 1'b1,
      One, One, One, One, 33'h0_8000_0000, StOk},
    '{ActScale, P, N, 32'd1, 32'hFFFF_FFFF, Z, Z, Z, Z, N, 1'b0, Z, Z, Z, Z, 33'd0, StOk},
    // negate of the most negative value saturates
    '{ActNegate, N, N, N, N, Z, Z, Z, Z, Z, 1'b1, P, P, P, P, 33'h1_0000_0000, StOvf},
    '{ActNegate, P, 32'hFFFF_FFFF, Z, 32'd12345, Z, Z, Z, Z, Z, 1'b0,
      Z, Z, Z, Z, 33'd0, StOk},
    '{ActConj, 32'd1, 32'd2, 32'd3, 32'd4, Z, Z, Z, Z, Z, 1'b1,
      32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFD, 32'd4, 33'd5, StOk},
    '{ActConj, N, P, Z, N, Z, Z, Z, Z, Z, 1'b0, Z, Z, Z, Z, 33'd0, StOk},
    // inverse of a zero quaternion
    '{ActInverse, Z, Z, Z, Z, Z, Z, Z, Z, Z, 1'b1, Z, Z, Z, Z, 33'd0, StZero},
    // inverse below the threshold saturates by conjugate sign
    '{ActInverse, 32'd5, 32'hFFFF_FFFD, Z, 32'd1, Z, Z, Z, Z, Z, 1'b1,
      N, P, Z, P, 33'd5, StZero},
    '{ActInverse, Z, Z, Z, One, Z, Z, Z, Z, Z, 1'b1, Z, Z, Z, One, 33'h0_4000_0000, StOk},
    '{ActInverse, N, N, N, N, Z, Z, Z, Z, Z, 1'b0, Z, Z, Z, Z, 33'd0, StOk},
    '{ActInverse, 32'd1000, 32'd77, 32'hFFFF_0000, 32'd3, Z, Z, Z, Z, Z, 1'b0,
      Z, Z, Z, Z, 33'd0, StOk},
    // normalize below the threshold keeps A
    '{ActNormalize, 32'd100, Z, Z, Z, Z, Z, Z, Z, Z, 1'b1, 32'd100, Z, Z, Z, 33'd100, StZero},
    // just above the threshold
    '{ActNormalize, 32'd108, Z, Z, Z, Z, Z, Z, Z, Z, 1'b1, One, Z, Z, Z, 33'd108, StOk},
    '{ActNormalize, P, P, P, P, Z, Z, Z, Z, Z, 1'b0, Z, Z, Z, Z, 33'd0, StOk},
    '{ActNormalize, N, N, N, N, Z, Z, Z, Z, Z, 1'b0, Z, Z, Z, Z, 33'd0, StOk},
    // unused action code gives a zero quaternion
    '{ActUnused, P, P, P, P, N, N, N, N, N, 1'b1, Z, Z, Z, Z, 33'h0_FFFF_FFFE, StOk},
    '{ActScale, 32'd3, 32'hFFFF_FFF0, P, N, Z, Z, Z, Z, 32'hC000_0000, 1'b0,
      Z, Z, Z, Z, 33'd0, StOk}
  };

  // Mismatch report: one line per failure, counted.
  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h, expected %h", what, got, want);
    mismatches++;
  endtask

  // Offers one word, waits for it to be taken, records its expected result,
  // and sometimes leaves a gap before the next word.
  task automatic send_word(quat_word_t w, quat_result_t exp_res);
    action_i <= w.act;
    a_x_i <= w.a[0]; a_y_i <= w.a[1]; a_z_i <= w.a[2]; a_w_i <= w.a[3];
    b_x_i <= w.b[0]; b_y_i <= w.b[1]; b_z_i <= w.b[2]; b_w_i <= w.b[3];
    scale_factor_i <= w.s;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    expected_results.push_back(exp_res);
    if (!quiet && !hold_req && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] rand_comp();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = P;
      1: v = N;
      2: v = Z;
      3, 4: v = 32'($urandom_range(0, 300));
      5, 6: v = $urandom >> 1;   // around unit scale
      default: v = $urandom;
    endcase
    if ($urandom_range(0, 1) == 1 && v != N) v = -v;
    return v;
  endfunction

  function automatic quat_word_t rand_word(logic [15:0] thr);
    quat_word_t w;
    int unsigned lim;
    w.act = 3'($urandom_range(0, 7));
    // Some words have a tiny A so that the zero-norm paths come up often.
    lim = 32'(thr) / 2 + 2;
    for (int i = 0; i < 4; i++) begin
      w.b[i] = rand_comp();
      if ($urandom_range(0, 4) == 0) begin
        w.a[i] = 32'($urandom_range(0, lim));
        if ($urandom_range(0, 1) == 1) w.a[i] = -w.a[i];
      end else begin
        w.a[i] = rand_comp();
      end
    end
    w.s = rand_comp();
    return w;
  endfunction

  task automatic write_threshold(logic [15:0] val);
    wait (expected_results.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    zero_thr = val;
  endtask

  // Sender: directed table, then random phases at several thresholds.
  initial begin
    quat_word_t w;
    quat_result_t e;
    logic [15:0] thr_list[4];
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (DirTable[k]) begin
      w.act = DirTable[k].act;
      w.a = '{DirTable[k].ax, DirTable[k].ay, DirTable[k].az, DirTable[k].aw};
      w.b = '{DirTable[k].bx, DirTable[k].by, DirTable[k].bz, DirTable[k].bw};
      w.s = DirTable[k].sc;
      if (DirTable[k].chk) begin
        e.r = '{DirTable[k].ex, DirTable[k].ey, DirTable[k].ez, DirTable[k].ew};
        e.magn = DirTable[k].em;
        e.st = DirTable[k].es;
      end else begin
        e = predict_quat(w, zero_thr);
      end
      send_word(w, e);
    end
    in_valid_i <= 1'b0;
    thr_list = '{16'd0, 16'hFFFF, 16'($urandom_range(1, 65534)), ThrReset};
    foreach (thr_list[p]) begin
      write_threshold(thr_list[p]);
      quiet = (p == 3);
      for (int n = 0; n < PhaseWords; n++) begin
        // Once, the receiver holds off while words keep coming so the block fills.
        if (p == 0 && n == 40) hold_req = 1'b1;
        w = rand_word(zero_thr);
        send_word(w, predict_quat(w, zero_thr));
      end
      in_valid_i <= 1'b0;
    end
    stim_done = 1'b1;
  end

  // Receiver: checks each taken result word against the oldest expectation
  // and drives out_ready_i with random stall bursts.
  initial begin
    quat_result_t e;
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report("unexpected word", {31'd0, magnitude_o}, 64'd0);
        end else begin
          e = expected_results.pop_front();
          if (r_x_o !== e.r[0]) report("r_x", 64'(r_x_o), 64'(e.r[0]));
          if (r_y_o !== e.r[1]) report("r_y", 64'(r_y_o), 64'(e.r[1]));
          if (r_z_o !== e.r[2]) report("r_z", 64'(r_z_o), 64'(e.r[2]));
          if (r_w_o !== e.r[3]) report("r_w", 64'(r_w_o), 64'(e.r[3]));
          if (magnitude_o !== e.magn) report("magnitude", 64'(magnitude_o), 64'(e.magn));
          if (status_o !== e.st) report("status", 64'(status_o), 64'(e.st));
        end
      end
      if (hold_req) begin
        // Long hold-off, counted here, while the sender keeps offering.
        stall = HoldCycles;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(0, 13);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when nothing moves on either channel for too long.
  initial begin
    int unsigned still;
    still = 0;
    while (still < WatchLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) still = 0;
      else still++;
    end
    $display("tb_quaternion_arithmetic_unit NOT OK");
    $finish;
  end

  // End of run: drain, wait out the pipeline, then give the verdict.
  initial begin
    wait (stim_done);
    wait (expected_results.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      report("words left over", 64'(expected_results.size()), 64'd0);
    end
    if (mismatches == 0) begin
      $display("tb_quaternion_arithmetic_unit OK");
    end else begin
      $display("tb_quaternion_arithmetic_unit NOT OK");
    end
    $finish;
  end

endmodule
